// ===== rtl/sgh_pkg.sv =====
// Package for the speech gate: register indexes, reset values, widths and the
// configuration struct shared by the configuration block, the core and the top level.
// No dependencies.
package sgh_pkg;

	// Field widths.
	localparam int PROB_W       = 16;
	localparam int MIN_W        = 24;
	localparam int HOP_W        = 13;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int COUNT_WIDTH  = 24;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROB_THRESHOLD      = 3'd0,
		REG_HYSTERESIS_DROP     = 3'd1,
		REG_MIN_SPEECH_SAMPLES  = 3'd2,
		REG_MIN_SILENCE_SAMPLES = 3'd3,
		REG_HOP_SAMPLES         = 3'd4
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [PROB_W-1:0] RST_PROB_THRESHOLD      = 16'd32768;
	localparam logic [PROB_W-1:0] RST_HYSTERESIS_DROP     = 16'd9830;
	localparam logic [MIN_W-1:0]  RST_MIN_SPEECH_SAMPLES  = 24'd4000;
	localparam logic [MIN_W-1:0]  RST_MIN_SILENCE_SAMPLES = 24'd8000;
	localparam logic [HOP_W-1:0]  RST_HOP_SAMPLES         = 13'd512;

	// Current settings as seen by the core.
	typedef struct packed {
		logic [PROB_W-1:0] prob_threshold;
		logic [PROB_W-1:0] hysteresis_drop;
		logic [MIN_W-1:0]  min_speech_samples;
		logic [MIN_W-1:0]  min_silence_samples;
		logic [HOP_W-1:0]  hop_samples;
	} cfg_t;

endpackage

// ===== rtl/sgh_prob_if.sv =====
// Stream interface for speech probabilities (one per window).
// Depends on sgh_pkg for the field width.
interface sgh_prob_if;
	logic                         valid;
	logic                         ready;
	logic [sgh_pkg::PROB_W-1:0]   speech_prob;

	modport source (output valid, output speech_prob, input ready);
	modport sink   (input valid, input speech_prob, output ready);
endinterface

// ===== rtl/sgh_dec_if.sv =====
// Stream interface for speech decisions (one per window).
// No dependencies.
interface sgh_dec_if;
	logic valid;
	logic ready;
	logic is_speech;

	modport source (output valid, output is_speech, input ready);
	modport sink   (input valid, input is_speech, output ready);
endinterface

// ===== rtl/sgh_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on sgh_pkg for the widths.
interface sgh_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sgh_pkg::CFG_IDX_W-1:0]    index;
	logic [sgh_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sgh_cfg.sv =====
// Configuration register bank for the speech gate.
// Depends on sgh_pkg and sgh_cfg_if.
module sgh_cfg (
	input  logic              clk,
	input  logic              arst_n,
	sgh_cfg_if.sink           wr,
	output sgh_pkg::cfg_t     cfg
);

	sgh_pkg::cfg_t cfg_q;
	logic          wr_fire;

	// Writes are always taken; unknown indexes are dropped.
	assign wr.ready = 1'b1;
	assign wr_fire  = wr.valid;
	assign cfg      = cfg_q;

	// Register file with reset defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prob_threshold      <= sgh_pkg::RST_PROB_THRESHOLD;
			cfg_q.hysteresis_drop     <= sgh_pkg::RST_HYSTERESIS_DROP;
			cfg_q.min_speech_samples  <= sgh_pkg::RST_MIN_SPEECH_SAMPLES;
			cfg_q.min_silence_samples <= sgh_pkg::RST_MIN_SILENCE_SAMPLES;
			cfg_q.hop_samples         <= sgh_pkg::RST_HOP_SAMPLES;
		end else if (wr_fire) begin
			unique case (wr.index)
				sgh_pkg::REG_PROB_THRESHOLD:
					cfg_q.prob_threshold <= wr.data[sgh_pkg::PROB_W-1:0];
				sgh_pkg::REG_HYSTERESIS_DROP:
					cfg_q.hysteresis_drop <= wr.data[sgh_pkg::PROB_W-1:0];
				sgh_pkg::REG_MIN_SPEECH_SAMPLES:
					cfg_q.min_speech_samples <= wr.data[sgh_pkg::MIN_W-1:0];
				sgh_pkg::REG_MIN_SILENCE_SAMPLES:
					cfg_q.min_silence_samples <= wr.data[sgh_pkg::MIN_W-1:0];
				sgh_pkg::REG_HOP_SAMPLES:
					cfg_q.hop_samples <= wr.data[sgh_pkg::HOP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/sgh_core.sv =====
// Decision core: gate state, elapsed counters and the per-window decision.
// Depends on sgh_pkg.
module sgh_core #(
	parameter int COUNT_WIDTH = sgh_pkg::COUNT_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sgh_pkg::cfg_t              cfg,
	input  logic                       step,
	input  logic [sgh_pkg::PROB_W-1:0] speech_prob,
	output logic                       is_speech
);

	// Compare width covers both the counters and the minimum registers.
	localparam int CMP_W = (COUNT_WIDTH > sgh_pkg::MIN_W) ? COUNT_WIDTH : sgh_pkg::MIN_W;

	logic                   triggered_q, start_pending_q, end_pending_q;
	logic [COUNT_WIDTH-1:0] speech_elapsed_q, silence_elapsed_q;

	logic                   triggered_d, start_pending_d, end_pending_d;
	logic [COUNT_WIDTH-1:0] speech_elapsed_d, silence_elapsed_d;

	logic [COUNT_WIDTH:0]   speech_sum, silence_sum;
	logic [COUNT_WIDTH-1:0] speech_adv, silence_adv;
	logic                   above, below, hold;
	logic [sgh_pkg::PROB_W:0] prob_plus_drop;

	// Saturating advance of the pending counters by one hop.
	always_comb begin
		speech_sum  = {1'b0, speech_elapsed_q} + (COUNT_WIDTH+1)'(cfg.hop_samples);
		silence_sum = {1'b0, silence_elapsed_q} + (COUNT_WIDTH+1)'(cfg.hop_samples);
		speech_adv  = speech_elapsed_q;
		silence_adv = silence_elapsed_q;
		if (start_pending_q) begin
			speech_adv = speech_sum[COUNT_WIDTH] ? '1 : speech_sum[COUNT_WIDTH-1:0];
		end
		if (end_pending_q) begin
			silence_adv = silence_sum[COUNT_WIDTH] ? '1 : silence_sum[COUNT_WIDTH-1:0];
		end
	end

	// Threshold compares.
	assign above          = speech_prob > cfg.prob_threshold;
	assign below          = speech_prob < cfg.prob_threshold;
	assign prob_plus_drop = {1'b0, speech_prob} + {1'b0, cfg.hysteresis_drop};
	assign hold           = prob_plus_drop > {1'b0, cfg.prob_threshold};

	// Rule evaluation; the first matching rule decides.
	always_comb begin
		triggered_d       = triggered_q;
		start_pending_d   = start_pending_q;
		end_pending_d     = end_pending_q & ~above;
		speech_elapsed_d  = speech_adv;
		silence_elapsed_d = silence_adv;
		is_speech         = 1'b0;
		priority if (above && !start_pending_q) begin
			start_pending_d  = 1'b1;
			speech_elapsed_d = '0;
		end else if (above && !triggered_q) begin
			if (CMP_W'(speech_adv) >= CMP_W'(cfg.min_speech_samples)) begin
				triggered_d = 1'b1;
				is_speech   = 1'b1;
			end
		end else if (below && !triggered_q) begin
			start_pending_d = 1'b0;
			end_pending_d   = 1'b0;
		end else if (triggered_q && hold) begin
			is_speech = 1'b1;
		end else if (triggered_q && below) begin
			if (!end_pending_q) begin
				end_pending_d     = 1'b1;
				silence_elapsed_d = '0;
			end
			if (CMP_W'(silence_elapsed_d) < CMP_W'(cfg.min_silence_samples)) begin
				is_speech = 1'b1;
			end else begin
				triggered_d     = 1'b0;
				start_pending_d = 1'b0;
				end_pending_d   = 1'b0;
			end
		end else begin
			is_speech = 1'b0;
		end
	end

	// State update, one window per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triggered_q       <= 1'b0;
			start_pending_q   <= 1'b0;
			end_pending_q     <= 1'b0;
			speech_elapsed_q  <= '0;
			silence_elapsed_q <= '0;
		end else if (step) begin
			triggered_q       <= triggered_d;
			start_pending_q   <= start_pending_d;
			end_pending_q     <= end_pending_d;
			speech_elapsed_q  <= speech_elapsed_d;
			silence_elapsed_q <= silence_elapsed_d;
		end
	end

endmodule

// ===== rtl/speech_gate_hysteresis.sv =====
// Speech gate with hysteresis and hangover: one decision per speech probability.
// The input register takes each probability at its transfer; the decision made from it is
// then registered into the result register, which holds it until it is taken.
// Throughput: one item per cycle while results are taken; while a result waits, the input
// register still takes one item and then holds it until the result is taken.
// Reset clears the gate state and counters and loads the register defaults.
// Depends on sgh_pkg, sgh_prob_if, sgh_dec_if, sgh_cfg_if, sgh_cfg and sgh_core.
module speech_gate_hysteresis #(
	parameter int COUNT_WIDTH = sgh_pkg::COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	sgh_prob_if.sink    prob,
	sgh_dec_if.source   decision,
	sgh_cfg_if.sink     cfg_wr
);

	sgh_pkg::cfg_t              cfg;
	logic                       valid_s1;
	logic [sgh_pkg::PROB_W-1:0] prob_s1;
	logic                       out_valid_q;
	logic                       is_speech_q;
	logic                       advance;
	logic                       step;
	logic                       core_is_speech;

	// The stage moves when the result register is free or being emptied.
	assign advance     = !out_valid_q || decision.ready;
	assign step        = valid_s1 && advance;
	assign prob.ready  = !valid_s1 || advance;

	assign decision.valid     = out_valid_q;
	assign decision.is_speech = is_speech_q;

	sgh_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_wr),
		.cfg    (cfg)
	);

	sgh_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.speech_prob (prob_s1),
		.is_speech   (core_is_speech)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prob.ready) begin
			valid_s1 <= prob.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prob.ready && prob.valid) begin
			prob_s1 <= prob.speech_prob;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			is_speech_q <= core_is_speech;
		end
	end

endmodule
